// File: rtl/sspc_pkg.sv
// shared types, constants and crc helper for the servo status packet checker
// used by sspc_parser and servo_status_packet_checker_core; no dependencies
`default_nettype none

package sspc_pkg;

    // packet constants
    localparam logic [7:0]  ID_ANY       = 8'hFE;
    localparam logic [7:0]  INSTR_STATUS = 8'h55;
    localparam logic [15:0] CRC_POLY     = 16'h8005;
    localparam logic [15:0] LEN_OVERHEAD = 16'd4;
    localparam logic [7:0]  HDR_BYTES [4] = '{8'hFF, 8'hFF, 8'hFD, 8'h00};

    // register map, indexed by paddr[2]
    localparam logic REG_EXPECTED_ID  = 1'b0;
    localparam logic REG_EXPECTED_LEN = 1'b1;

    // parser phase
    typedef enum logic [3:0] {
        PH_HEADER = 4'd0,
        PH_ID     = 4'd1,
        PH_LEN_LO = 4'd2,
        PH_LEN_HI = 4'd3,
        PH_INSTR  = 4'd4,
        PH_ERROR  = 4'd5,
        PH_PARAM  = 4'd6,
        PH_CRC_LO = 4'd7,
        PH_CRC_HI = 4'd8
    } t_phase;

    // result kind
    typedef enum logic [1:0] {
        KIND_PARAM  = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    // reject cause
    typedef enum logic [2:0] {
        CAUSE_NONE    = 3'd0,
        CAUSE_HEADER  = 3'd1,
        CAUSE_ID      = 3'd2,
        CAUSE_LENGTH  = 3'd3,
        CAUSE_INSTR   = 3'd4,
        CAUSE_CRC     = 3'd5,
        CAUSE_TIMEOUT = 3'd6
    } t_cause;

    // configuration registers seen by the parser
    typedef struct packed {
        logic [7:0]  expected_id;
        logic [15:0] expected_param_len;
    } t_cfg;

    // one result from the parser
    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [7:0]  param_byte;
        logic [15:0] param_index;
        logic [7:0]  sender_id;
        logic [7:0]  error_byte;
        t_cause      cause;
    } t_result;

    // crc-16, poly 0x8005, msb first, one byte
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/sspc_parser.sv
// packet phase tracker, field checks and running crc for one byte per cycle
// depends on sspc_pkg
`default_nettype none

module sspc_parser (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sspc_pkg::t_cfg    i_cfg,
    input  wire logic              i_valid,
    input  wire logic [7:0]        i_rx_byte,
    input  wire logic              i_timed_out,
    output sspc_pkg::t_result      o_res
);
    import sspc_pkg::*;

    t_phase      r_phase,       n_phase;
    logic [1:0]  r_header_pos,  n_header_pos;
    logic [15:0] r_crc_acc,     n_crc_acc;
    logic [15:0] r_param_count, n_param_count;
    logic [7:0]  r_seen_id,     n_seen_id;
    logic [7:0]  r_seen_error,  n_seen_error;
    logic [7:0]  r_crc_low,     n_crc_low;

    logic [15:0] w_total;
    logic [15:0] w_crc_next;
    logic [15:0] w_count_inc;
    logic        w_id_ok;

    // shared datapath terms
    assign w_total     = i_cfg.expected_param_len + LEN_OVERHEAD;
    assign w_crc_next  = crc16_feed(r_crc_acc, i_rx_byte);
    assign w_count_inc = r_param_count + 16'd1;
    assign w_id_ok     = (i_cfg.expected_id == ID_ANY) || (i_cfg.expected_id == i_rx_byte);

    // next state
    always_comb begin
        n_phase       = r_phase;
        n_header_pos  = r_header_pos;
        n_crc_acc     = r_crc_acc;
        n_param_count = r_param_count;
        n_seen_id     = r_seen_id;
        n_seen_error  = r_seen_error;
        n_crc_low     = r_crc_low;
        if (i_valid) begin
            // any packet end drops back to the first header byte
            n_phase       = PH_HEADER;
            n_header_pos  = 2'd0;
            n_crc_acc     = 16'd0;
            n_param_count = 16'd0;
            n_seen_id     = 8'd0;
            n_seen_error  = 8'd0;
            n_crc_low     = 8'd0;
            if (!i_timed_out) begin
                unique case (r_phase)
                    PH_HEADER: begin
                        if (i_rx_byte == HDR_BYTES[r_header_pos]) begin
                            n_crc_acc    = w_crc_next;
                            n_header_pos = r_header_pos + 2'd1;
                            n_phase      = (r_header_pos == 2'd3) ? PH_ID : PH_HEADER;
                        end
                    end
                    PH_ID: begin
                        if (w_id_ok) begin
                            n_crc_acc = w_crc_next;
                            n_seen_id = i_rx_byte;
                            n_phase   = PH_LEN_LO;
                        end
                    end
                    PH_LEN_LO: begin
                        if (i_rx_byte == w_total[7:0]) begin
                            n_crc_acc = w_crc_next;
                            n_seen_id = r_seen_id;
                            n_phase   = PH_LEN_HI;
                        end
                    end
                    PH_LEN_HI: begin
                        if (i_rx_byte == w_total[15:8]) begin
                            n_crc_acc = w_crc_next;
                            n_seen_id = r_seen_id;
                            n_phase   = PH_INSTR;
                        end
                    end
                    PH_INSTR: begin
                        if (i_rx_byte == INSTR_STATUS) begin
                            n_crc_acc = w_crc_next;
                            n_seen_id = r_seen_id;
                            n_phase   = PH_ERROR;
                        end
                    end
                    PH_ERROR: begin
                        n_crc_acc    = w_crc_next;
                        n_seen_id    = r_seen_id;
                        n_seen_error = i_rx_byte;
                        n_phase      = (i_cfg.expected_param_len == 16'd0) ? PH_CRC_LO
                                                                          : PH_PARAM;
                    end
                    PH_PARAM: begin
                        n_crc_acc     = w_crc_next;
                        n_seen_id     = r_seen_id;
                        n_seen_error  = r_seen_error;
                        n_param_count = w_count_inc;
                        n_phase       = ((w_count_inc >= i_cfg.expected_param_len) ||
                                         (w_count_inc == 16'd0)) ? PH_CRC_LO : PH_PARAM;
                    end
                    PH_CRC_LO: begin
                        n_crc_acc     = r_crc_acc;
                        n_param_count = r_param_count;
                        n_seen_id     = r_seen_id;
                        n_seen_error  = r_seen_error;
                        n_crc_low     = i_rx_byte;
                        n_phase       = PH_CRC_HI;
                    end
                    PH_CRC_HI: begin
                        n_phase = PH_HEADER;
                    end
                    default: begin
                        n_phase = PH_HEADER;
                    end
                endcase
            end
        end
    end

    // result for the current byte
    always_comb begin
        o_res             = '0;
        o_res.kind        = KIND_PARAM;
        o_res.cause       = CAUSE_NONE;
        o_res.sender_id   = r_seen_id;
        o_res.error_byte  = r_seen_error;
        if (i_valid) begin
            if (i_timed_out) begin
                o_res.valid = 1'b1;
                o_res.kind  = KIND_REJECT;
                o_res.cause = CAUSE_TIMEOUT;
            end else begin
                unique case (r_phase)
                    PH_HEADER: begin
                        if (i_rx_byte != HDR_BYTES[r_header_pos]) begin
                            o_res.valid = 1'b1;
                            o_res.kind  = KIND_REJECT;
                            o_res.cause = CAUSE_HEADER;
                        end
                    end
                    PH_ID: begin
                        o_res.sender_id = i_rx_byte;
                        if (!w_id_ok) begin
                            o_res.valid = 1'b1;
                            o_res.kind  = KIND_REJECT;
                            o_res.cause = CAUSE_ID;
                        end
                    end
                    PH_LEN_LO: begin
                        if (i_rx_byte != w_total[7:0]) begin
                            o_res.valid = 1'b1;
                            o_res.kind  = KIND_REJECT;
                            o_res.cause = CAUSE_LENGTH;
                        end
                    end
                    PH_LEN_HI: begin
                        if (i_rx_byte != w_total[15:8]) begin
                            o_res.valid = 1'b1;
                            o_res.kind  = KIND_REJECT;
                            o_res.cause = CAUSE_LENGTH;
                        end
                    end
                    PH_INSTR: begin
                        if (i_rx_byte != INSTR_STATUS) begin
                            o_res.valid = 1'b1;
                            o_res.kind  = KIND_REJECT;
                            o_res.cause = CAUSE_INSTR;
                        end
                    end
                    PH_PARAM: begin
                        o_res.valid       = 1'b1;
                        o_res.kind        = KIND_PARAM;
                        o_res.param_byte  = i_rx_byte;
                        o_res.param_index = r_param_count;
                    end
                    PH_CRC_HI: begin
                        o_res.valid = 1'b1;
                        if ({i_rx_byte, r_crc_low} != r_crc_acc) begin
                            o_res.kind  = KIND_REJECT;
                            o_res.cause = CAUSE_CRC;
                        end else begin
                            o_res.kind  = KIND_ACCEPT;
                        end
                    end
                    default: begin
                        o_res.valid = 1'b0;
                    end
                endcase
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HEADER;
            r_header_pos  <= 2'd0;
            r_crc_acc     <= 16'd0;
            r_param_count <= 16'd0;
            r_seen_id     <= 8'd0;
            r_seen_error  <= 8'd0;
            r_crc_low     <= 8'd0;
        end else begin
            r_phase       <= n_phase;
            r_header_pos  <= n_header_pos;
            r_crc_acc     <= n_crc_acc;
            r_param_count <= n_param_count;
            r_seen_id     <= n_seen_id;
            r_seen_error  <= n_seen_error;
            r_crc_low     <= n_crc_low;
        end
    end

`ifndef SYNTHESIS
    // a reject always carries a cause, other kinds never do
    a_cause_matches_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ((o_res.kind == KIND_REJECT) == (o_res.cause != CAUSE_NONE)))
        else $error("reject cause does not match result kind");

    // a timeout always restarts the packet
    a_timeout_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_timed_out |=> (r_phase == PH_HEADER) && (r_header_pos == 2'd0)
                                   && (r_crc_acc == 16'd0))
        else $error("timeout did not restart the packet");

    // header position only moves while in the header phase
    a_header_pos_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_header_pos != 2'd0) |-> (r_phase == PH_HEADER))
        else $error("header position set outside header phase");
`endif

endmodule

`default_nettype wire

// File: rtl/servo_status_packet_checker_core.sv
// servo status packet checker top level: stream ports, apb registers, result register
// depends on sspc_pkg and sspc_parser
//
// usage:
//   s_* stream carries received bytes, one per request: tdata is the byte, tuser flags
//   that the byte wait timed out (the byte is then ignored and the packet aborted).
//   m_* stream carries results: a parameter byte with its index, a packet accept, or a
//   packet reject with its cause. other bytes give a result only when they fail a check.
//   registers on the apb port: expected_id at 0x0 (0xFE matches any sender, reset 0xFE),
//   expected_param_len at 0x4 (reset 0). write them only while no packet is in flight.
// timing:
//   one byte is taken every cycle while s_tready is high; its result, if any, is
//   registered in the result register and shown on m_*. the whole check for a
//   byte, including the crc update, is combinational logic ahead of that register.
//   when the receiver stalls, the held result stays in the result register and s_tready
//   drops until it is taken; a request that gives no result still passes while the
//   result register is empty or draining.
// reset:
//   synchronous, active low; clears the parser to the first header byte, empties the
//   result register and loads the register reset values.
`default_nettype none

module servo_status_packet_checker_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [0:0]  s_tuser,   // [0] timed_out
    // result output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [7:0] param_byte, [23:8] param_index,
                                        // [31:24] sender_id, [39:32] error_byte,
                                        // [42:40] fail_cause, [47:43] zero
    output logic [1:0]       m_tuser,   // [1:0] kind
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import sspc_pkg::*;

    logic [7:0]  r_expected_id;
    logic [15:0] r_expected_len;
    logic        r_out_valid;
    t_result     r_out;

    t_cfg        w_cfg;
    t_result     w_res;
    logic        w_in_acc;
    logic        w_cfg_wr;

    // apb register file
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id  <= ID_ANY;
            r_expected_len <= 16'd0;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_EXPECTED_ID) begin
                r_expected_id <= pwdata[7:0];
            end else begin
                r_expected_len <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_EXPECTED_ID:  prdata = {24'd0, r_expected_id};
            REG_EXPECTED_LEN: prdata = {16'd0, r_expected_len};
            default:          prdata = 32'd0;
        endcase
    end

    assign w_cfg.expected_id        = r_expected_id;
    assign w_cfg.expected_param_len = r_expected_len;

    // input request handshake
    assign s_tready = !r_out_valid || m_tready;
    assign w_in_acc = s_tvalid && s_tready;

    sspc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (w_in_acc),
        .i_rx_byte   (s_tdata),
        .i_timed_out (s_tuser[0]),
        .o_res       (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc && w_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_res.valid) begin
            r_out <= w_res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out.kind;
    assign m_tdata  = {5'd0, r_out.cause, r_out.error_byte, r_out.sender_id,
                       r_out.param_index, r_out.param_byte};

`ifndef SYNTHESIS
    // an empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_tready)
        else $error("input stalled with empty result register");

    // a produced result lands in the result register
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && w_res.valid |=> r_out_valid)
        else $error("result lost");

    // a write to expected_id takes effect at the write edge
    a_id_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr && (paddr[2] == REG_EXPECTED_ID) |=> r_expected_id == $past(pwdata[7:0]))
        else $error("expected_id write lost");
`endif

endmodule

`default_nettype wire
